@@ src/bbcf_pkg.sv @@
`default_nettype none

package bbcf_pkg;

    // Block dimensions
    localparam int SECTIONS         = 4;
    localparam int FILTER_SETS      = 4;
    localparam int SAMPLE_BITS      = 10;
    localparam int DEFINED_SETS     = 4;
    localparam int DEFINED_SECTIONS = 4;

    // Fixed-point formats
    localparam int FRAC_IN   = 16;
    localparam int COEF_FRAC = 22;
    localparam int COEF_W    = 25;
    localparam int DELAY_W   = 40;
    localparam int ACC_W     = 43;
    localparam int OUT_W     = 32;
    localparam int PROD_W    = COEF_W + DELAY_W;
    localparam int LO_W      = DELAY_W / 2;
    localparam int HI_W      = DELAY_W - LO_W;
    localparam int MODE_W    = 2;
    localparam int TAPS      = 5;

    localparam int SET_W  = (FILTER_SETS > 1) ? $clog2(FILTER_SETS) : 1;
    localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int ROWS   = FILTER_SETS * SECTIONS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DSET_W = (DEFINED_SETS > 1) ? $clog2(DEFINED_SETS) : 1;
    localparam int DSEC_W = (DEFINED_SECTIONS > 1) ? $clog2(DEFINED_SECTIONS) : 1;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef logic [APB_ADDR_W-3:0] t_reg_idx;
    localparam t_reg_idx REG_FILTER_MODE = '0;

    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [DELAY_W-1:0] t_delay;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [OUT_W-1:0]   t_out;
    typedef logic [SET_W-1:0]          t_set;
    typedef logic [SEC_W-1:0]          t_sec;
    typedef logic [ROW_W-1:0]          t_row_addr;

    typedef enum logic [2:0] {
        TAP_B0,
        TAP_B1,
        TAP_B2,
        TAP_A1,
        TAP_A2
    } t_tap;

    // One memory row: both delay words of one section of one set
    typedef struct packed {
        t_delay z1;
        t_delay z2;
    } t_row;

    typedef struct packed {
        t_coef  coef;
        t_delay operand;
    } t_mac_req;

    typedef struct packed {
        logic      rd_en;
        t_row_addr rd_addr;
        logic      wr_en;
        t_row_addr wr_addr;
    } t_ram_req;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_FRAC - 1);

    localparam t_acc DELAY_MAX = {{(ACC_W - DELAY_W + 1){1'b0}}, {(DELAY_W - 1){1'b1}}};
    localparam t_acc DELAY_MIN = ~DELAY_MAX;
    localparam t_acc OUT_MAX   = {{(ACC_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam t_acc OUT_MIN   = ~OUT_MAX;

    // Converts a coefficient given in units of 1e-8 to Q2.22, rounding half away
    function automatic t_coef qc(longint n);
        longint m;
        if (n >= 0) begin
            m = (n * 4194304 + 50000000) / 100000000;
        end else begin
            m = -(((-n) * 4194304 + 50000000) / 100000000);
        end
        return t_coef'(m);
    endfunction

    // Per set, per section: b0, b1, b2, a1, a2
    localparam t_coef COEF_TABLE [DEFINED_SETS][DEFINED_SECTIONS][TAPS] = '{
        '{ // ECG
            '{qc(28064917), qc(56129834), qc(28064917), qc(70682283), qc(15621030)},
            '{qc(100000000), qc(200000000), qc(100000000), qc(95028224), qc(54073140)},
            '{qc(100000000), qc(-200000000), qc(100000000), qc(-195360385), qc(95423412)},
            '{qc(100000000), qc(-200000000), qc(100000000), qc(-198048558), qc(98111344)}
        },
        '{ // EEG
            '{qc(735282), qc(1470564), qc(735282), qc(-95391350), qc(25311356)},
            '{qc(100000000), qc(200000000), qc(100000000), qc(-120596630), qc(60558332)},
            '{qc(100000000), qc(-200000000), qc(100000000), qc(-197690645), qc(97706395)},
            '{qc(100000000), qc(-200000000), qc(100000000), qc(-199071687), qc(99086813)}
        },
        '{ // EMG
            '{qc(1856301), qc(3712602), qc(1856301), qc(5159732), qc(36347401)},
            '{qc(100000000), qc(-200000000), qc(100000000), qc(-53945795), qc(39764934)},
            '{qc(100000000), qc(200000000), qc(100000000), qc(47319594), qc(70744137)},
            '{qc(100000000), qc(-200000000), qc(100000000), qc(-100211112), qc(74520226)}
        },
        '{ // EOG
            '{qc(9797471), qc(19594942), qc(9797471), qc(2977423), qc(4296318)},
            '{qc(100000000), qc(200000000), qc(100000000), qc(8383952), qc(46067709)},
            '{qc(100000000), qc(-200000000), qc(100000000), qc(-192167271), qc(92347975)},
            '{qc(100000000), qc(-200000000), qc(100000000), qc(-196758891), qc(96933514)}
        }
    };

    function automatic t_coef coef_lookup(t_set set_i, t_sec sec_i, t_tap tap);
        logic [DSET_W-1:0] si;
        logic [DSEC_W-1:0] ki;
        t_coef             c;
        si = DSET_W'(set_i);
        ki = DSEC_W'(sec_i);
        case (tap)
            TAP_B0:  c = COEF_TABLE[si][ki][0];
            TAP_B1:  c = COEF_TABLE[si][ki][1];
            TAP_B2:  c = COEF_TABLE[si][ki][2];
            TAP_A1:  c = COEF_TABLE[si][ki][3];
            TAP_A2:  c = COEF_TABLE[si][ki][4];
            default: c = '0;
        endcase
        return c;
    endfunction

    // Sections without coefficients pass their input through untouched
    function automatic logic is_bypass(t_set set_i, t_sec sec_i);
        return (32'(set_i) >= DEFINED_SETS) || (32'(sec_i) >= DEFINED_SECTIONS);
    endfunction

    function automatic t_row_addr row_addr(t_set set_i, t_sec sec_i);
        return ROW_W'(32'(set_i) * SECTIONS + 32'(sec_i));
    endfunction

    function automatic t_delay sat_delay(t_acc v);
        t_acc s;
        if (v > DELAY_MAX) begin
            s = DELAY_MAX;
        end else if (v < DELAY_MIN) begin
            s = DELAY_MIN;
        end else begin
            s = v;
        end
        return $signed(s[DELAY_W-1:0]);
    endfunction

    function automatic t_out sat_out(t_acc v);
        t_acc s;
        if (v > OUT_MAX) begin
            s = OUT_MAX;
        end else if (v < OUT_MIN) begin
            s = OUT_MIN;
        end else begin
            s = v;
        end
        return $signed(s[OUT_W-1:0]);
    endfunction

endpackage

`default_nettype wire

@@ src/bbcf_if.sv @@
`default_nettype none

interface bbcf_sample_if;
    logic                             valid;
    logic                             ready;
    logic [bbcf_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bbcf_result_if;
    logic                 valid;
    logic                 ready;
    bbcf_pkg::t_out       filtered;
    logic                 saturated;

    modport source (output valid, output filtered, output saturated, input ready);
    modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

`default_nettype wire

@@ src/bbcf_apb.sv @@
`default_nettype none

module bbcf_apb (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bbcf_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bbcf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bbcf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [bbcf_pkg::MODE_W-1:0]       o_filter_mode
);

    logic [bbcf_pkg::MODE_W-1:0] r_filter_mode;
    logic [bbcf_pkg::MODE_W-1:0] n_filter_mode;
    bbcf_pkg::t_reg_idx          reg_idx;
    logic                        wr_strobe;

    assign reg_idx   = paddr[bbcf_pkg::APB_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;

    always_comb begin
        n_filter_mode = r_filter_mode;
        if (wr_strobe && (reg_idx == bbcf_pkg::REG_FILTER_MODE)) begin
            n_filter_mode = pwdata[bbcf_pkg::MODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= '0;
        end else begin
            r_filter_mode <= n_filter_mode;
        end
    end

    assign prdata = (reg_idx == bbcf_pkg::REG_FILTER_MODE)
                  ? bbcf_pkg::APB_DATA_W'(r_filter_mode) : '0;
    assign o_filter_mode = r_filter_mode;

endmodule

`default_nettype wire

@@ src/bbcf_delay_ram.sv @@
`default_nettype none

module bbcf_delay_ram (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bbcf_pkg::t_ram_req i_req,
    input  wire bbcf_pkg::t_row     i_wr_data,
    output bbcf_pkg::t_row          o_rd_data
);

    bbcf_pkg::t_row             mem [bbcf_pkg::ROWS];
    bbcf_pkg::t_row             r_rd_data;
    logic                       r_rd_valid;
    logic [bbcf_pkg::ROWS-1:0]  r_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    // A row never written since reset reads as zero delay words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

@@ src/bbcf_mac.sv @@
`default_nettype none

module bbcf_mac (
    input  wire logic               i_clk,
    input  wire bbcf_pkg::t_mac_req i_req,
    output bbcf_pkg::t_acc          o_prod
);

    logic signed [bbcf_pkg::HI_W-1:0]                 op_hi;
    logic signed [bbcf_pkg::LO_W:0]                   op_lo;
    logic signed [bbcf_pkg::COEF_W+bbcf_pkg::HI_W-1:0] r_pp_hi;
    logic signed [bbcf_pkg::COEF_W+bbcf_pkg::LO_W:0]   r_pp_lo;
    logic signed [bbcf_pkg::PROD_W-1:0]               prod_full;
    bbcf_pkg::t_acc                                   r_prod;

    // The 40-bit operand is split into a signed upper half and an unsigned
    // lower half, so each partial product stays within a 25 by 21 multiplier.
    assign op_hi = $signed(i_req.operand[bbcf_pkg::DELAY_W-1:bbcf_pkg::LO_W]);
    assign op_lo = $signed({1'b0, i_req.operand[bbcf_pkg::LO_W-1:0]});

    always_ff @(posedge i_clk) begin
        r_pp_hi <= $signed(i_req.coef) * op_hi;
        r_pp_lo <= $signed(i_req.coef) * op_lo;
    end

    assign prod_full = (bbcf_pkg::PROD_W'(r_pp_hi) <<< bbcf_pkg::LO_W)
                     + bbcf_pkg::PROD_W'(r_pp_lo) + bbcf_pkg::ROUND_HALF;

    // Round to 16 fraction bits: add half an LSB, then floor.
    always_ff @(posedge i_clk) begin
        r_prod <= bbcf_pkg::t_acc'(prod_full >>> bbcf_pkg::COEF_FRAC);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ src/biosignal_biquad_cascade_filter.sv @@
`default_nettype none
// A result is offered once its item has passed through every section; a section
// without coefficients skips the multiply and write-back steps. Items do not
// overlap: a new item is accepted only in the idle state, once the seven-step read,
// multiply and write-back sequence of each section has run on the one shared multiplier.
// Reset (synchronous, active low) clears the mode register and the row valid bits,
// so every delay word reads as zero at once; no clearing pass is needed.

module biosignal_biquad_cascade_filter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    bbcf_sample_if.sink                          i_in,
    bbcf_result_if.source                        o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bbcf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bbcf_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bbcf_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    // The sequencer walks each section with coefficients through the step
    // codes below. The mode register picks the coefficient set when an item
    // is accepted; each set has its own rows in the delay memory, one row per
    // section holding z1 and z2. The multiplier is a two-stage pipeline: a product
    // passes its partial-product and product registers before it is accumulated.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // Step codes within one section
    localparam logic [2:0] STEP_A1   = 3'd1;  // issue a1*z1, capture the row
    localparam logic [2:0] STEP_A2   = 3'd2;  // issue a2*z2
    localparam logic [2:0] STEP_B1   = 3'd3;  // issue b1*z1, subtract a1*z1
    localparam logic [2:0] STEP_B2   = 3'd4;  // issue b2*z2, subtract a2*z2
    localparam logic [2:0] STEP_B0   = 3'd5;  // issue b0*w, write the row back
    localparam logic [2:0] STEP_SUM  = 3'd6;  // add b2*z2
    localparam logic [2:0] STEP_LAST = 3'd7;  // add b0*w, section output ready

    t_state                  r_state, n_state;
    logic [2:0]              r_step, n_step;
    bbcf_pkg::t_sec          r_sec, n_sec;
    bbcf_pkg::t_set          r_set, n_set;
    bbcf_pkg::t_acc          r_wacc, n_wacc;
    bbcf_pkg::t_acc          r_yacc, n_yacc;
    bbcf_pkg::t_delay        r_z1, n_z1;
    bbcf_pkg::t_delay        r_z2, n_z2;
    logic                    r_flag, n_flag;
    logic                    r_out_valid, n_out_valid;
    bbcf_pkg::t_out          r_filtered, n_filtered;
    logic                    r_out_sat, n_out_sat;

    logic [bbcf_pkg::MODE_W-1:0] filter_mode;
    bbcf_pkg::t_set          set_sel;
    logic                    accept;
    logic                    out_free;
    logic                    bypass;
    logic                    last_sec;
    bbcf_pkg::t_sec          sec_next;
    bbcf_pkg::t_delay        w_sat;
    logic                    w_clip;
    bbcf_pkg::t_acc          y_sum;
    bbcf_pkg::t_delay        y_sat;
    logic                    y_clip;
    bbcf_pkg::t_out          out_val;
    logic                    out_clip;
    bbcf_pkg::t_tap          tap;
    bbcf_pkg::t_mac_req      mac_req;
    bbcf_pkg::t_acc          prod;
    bbcf_pkg::t_ram_req      ram_req;
    bbcf_pkg::t_row          wr_row;
    bbcf_pkg::t_row          rd_row;

    bbcf_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_filter_mode (filter_mode)
    );

    bbcf_mac u_mac (
        .i_clk  (i_clk),
        .i_req  (mac_req),
        .o_prod (prod)
    );

    bbcf_delay_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .i_wr_data (wr_row),
        .o_rd_data (rd_row)
    );

    // A mode beyond the available sets falls back to the first set.
    assign set_sel = (32'(filter_mode) >= bbcf_pkg::FILTER_SETS)
                   ? '0 : bbcf_pkg::SET_W'(filter_mode);

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign bypass   = bbcf_pkg::is_bypass(r_set, r_sec);
    assign last_sec = (r_sec == bbcf_pkg::SEC_W'(bbcf_pkg::SECTIONS - 1));
    assign sec_next = bbcf_pkg::SEC_W'(r_sec + 1'b1);

    // Saturation of the new delay word, the section output and the result.
    assign w_sat    = bbcf_pkg::sat_delay(r_wacc);
    assign w_clip   = (bbcf_pkg::t_acc'(w_sat) != r_wacc);
    assign y_sum    = r_yacc + prod;
    assign y_sat    = bbcf_pkg::sat_delay(y_sum);
    assign y_clip   = (bbcf_pkg::t_acc'(y_sat) != y_sum);
    assign out_val  = bbcf_pkg::sat_out(r_wacc);
    assign out_clip = (bbcf_pkg::t_acc'(out_val) != r_wacc);

    // Multiplier operands follow the step. The first step takes z1 straight
    // from the memory read register, as the row has only just arrived.
    always_comb begin
        tap             = bbcf_pkg::TAP_B0;
        mac_req.operand = '0;
        case (r_step)
            STEP_A1: begin
                tap             = bbcf_pkg::TAP_A1;
                mac_req.operand = rd_row.z1;
            end
            STEP_A2: begin
                tap             = bbcf_pkg::TAP_A2;
                mac_req.operand = r_z2;
            end
            STEP_B1: begin
                tap             = bbcf_pkg::TAP_B1;
                mac_req.operand = r_z1;
            end
            STEP_B2: begin
                tap             = bbcf_pkg::TAP_B2;
                mac_req.operand = r_z2;
            end
            STEP_B0: begin
                tap             = bbcf_pkg::TAP_B0;
                mac_req.operand = w_sat;
            end
            default: begin
                tap             = bbcf_pkg::TAP_B0;
                mac_req.operand = '0;
            end
        endcase
        mac_req.coef = bbcf_pkg::coef_lookup(r_set, r_sec, tap);
    end

    // The row of the next section is fetched in the cycle before that section
    // starts. A row is written back at STEP_B0, ahead of the read of the next row
    // at STEP_LAST, and no item can reach the same row again before the write has
    // landed, so no forwarding is needed.
    always_comb begin
        ram_req.rd_en   = accept
                        || ((r_state == ST_RUN) && !last_sec
                            && ((r_step == STEP_LAST) || ((r_step == STEP_A1) && bypass)));
        ram_req.rd_addr = accept ? bbcf_pkg::row_addr(set_sel, '0)
                                 : bbcf_pkg::row_addr(r_set, sec_next);
        ram_req.wr_en   = (r_state == ST_RUN) && (r_step == STEP_B0);
        ram_req.wr_addr = bbcf_pkg::row_addr(r_set, r_sec);
        wr_row.z1       = w_sat;
        wr_row.z2       = r_z1;
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_sec       = r_sec;
        n_set       = r_set;
        n_wacc      = r_wacc;
        n_yacc      = r_yacc;
        n_z1        = r_z1;
        n_z2        = r_z2;
        n_flag      = r_flag;
        n_out_valid = r_out_valid;
        n_filtered  = r_filtered;
        n_out_sat   = r_out_sat;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RUN;
                    n_step  = STEP_A1;
                    n_sec   = '0;
                    n_set   = set_sel;
                    n_flag  = 1'b0;
                    n_wacc  = bbcf_pkg::ACC_W'(i_in.sample) << bbcf_pkg::FRAC_IN;
                end
            end
            ST_RUN: begin
                case (r_step)
                    STEP_A1: begin
                        if (bypass) begin
                            // The input passes through unchanged.
                            if (last_sec) begin
                                n_state = ST_DONE;
                            end else begin
                                n_sec = sec_next;
                            end
                        end else begin
                            n_z1   = rd_row.z1;
                            n_z2   = rd_row.z2;
                            n_step = STEP_A2;
                        end
                    end
                    STEP_A2: begin
                        n_step = STEP_B1;
                    end
                    STEP_B1: begin
                        n_wacc = r_wacc - prod;
                        n_step = STEP_B2;
                    end
                    STEP_B2: begin
                        n_wacc = r_wacc - prod;
                        n_step = STEP_B0;
                    end
                    STEP_B0: begin
                        n_yacc = prod;
                        n_flag = r_flag | w_clip;
                        n_step = STEP_SUM;
                    end
                    STEP_SUM: begin
                        n_yacc = r_yacc + prod;
                        n_step = STEP_LAST;
                    end
                    STEP_LAST: begin
                        n_wacc = bbcf_pkg::t_acc'(y_sat);
                        n_flag = r_flag | y_clip;
                        if (last_sec) begin
                            n_state = ST_DONE;
                        end else begin
                            n_sec  = sec_next;
                            n_step = STEP_A1;
                        end
                    end
                    default: begin
                        n_step = STEP_A1;
                    end
                endcase
            end
            ST_DONE: begin
                // Wait here only while an earlier result has not been taken.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_filtered  = out_val;
                    n_out_sat   = r_flag | out_clip;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_A1;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_sec       <= n_sec;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set      <= n_set;
        r_wacc     <= n_wacc;
        r_yacc     <= n_yacc;
        r_z1       <= n_z1;
        r_z2       <= n_z2;
        r_flag     <= n_flag;
        r_filtered <= n_filtered;
        r_out_sat  <= n_out_sat;
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.filtered  = r_filtered;
    assign o_out.saturated = r_out_sat;

`ifndef NO_ASSERTIONS
    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RUN) && (r_sec == '0) && !i_in.ready)
        else $error("accepted item did not start at the first section");

    a_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.wr_en |-> (r_state == ST_RUN) && !bypass)
        else $error("delay row written outside a filtering section");

    a_no_same_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
        else $error("delay row read and written in the same cycle");

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (32'(r_sec) < bbcf_pkg::SECTIONS))
        else $error("section counter out of range");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result offered without a finished item");
`endif

endmodule

`default_nettype wire

@@ tb/tb_biosignal_biquad_cascade_filter.sv @@
`timescale 1ns / 1ps

module tb_biosignal_biquad_cascade_filter;
    import bbcf_pkg::*;

    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam logic [APB_ADDR_W-1:0] MODE_ADDR = {REG_FILTER_MODE, 2'b00};
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 56;

    // Filter mode of each random phase. Both extremes appear, and every set is
    // visited twice so that its delay words must survive the other sets' traffic.
    localparam logic [MODE_W-1:0] PHASE_MODES [PHASES] = '{
        2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0
    };

    // Design coefficients in units of 1e-8, per set and section: b0, b1, b2, a1, a2.
    // The scoreboard turns them into Q2.22 itself.
    localparam longint COEF_E8 [DEFINED_SETS][DEFINED_SECTIONS][TAPS] = '{
        '{
            '{28064917, 56129834, 28064917, 70682283, 15621030},
            '{100000000, 200000000, 100000000, 95028224, 54073140},
            '{100000000, -200000000, 100000000, -195360385, 95423412},
            '{100000000, -200000000, 100000000, -198048558, 98111344}
        },
        '{
            '{735282, 1470564, 735282, -95391350, 25311356},
            '{100000000, 200000000, 100000000, -120596630, 60558332},
            '{100000000, -200000000, 100000000, -197690645, 97706395},
            '{100000000, -200000000, 100000000, -199071687, 99086813}
        },
        '{
            '{1856301, 3712602, 1856301, 5159732, 36347401},
            '{100000000, -200000000, 100000000, -53945795, 39764934},
            '{100000000, 200000000, 100000000, 47319594, 70744137},
            '{100000000, -200000000, 100000000, -100211112, 74520226}
        },
        '{
            '{9797471, 19594942, 9797471, 2977423, 4296318},
            '{100000000, 200000000, 100000000, 8383952, 46067709},
            '{100000000, -200000000, 100000000, -192167271, 92347975},
            '{100000000, -200000000, 100000000, -196758891, 96933514}
        }
    };

    // Shapes of the random sample segments. Wandering around mid-scale is the
    // realistic biosignal; holds at an extreme and full-scale toggling push the
    // high-gain sections towards clipping.
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_WANDER,
        SHAPE_HOLD,
        SHAPE_TOGGLE
    } t_shape;

    typedef struct packed {
        t_out filtered;
        logic saturated;
    } t_filter_result;

    // Bandpass predictor and scoreboard. It keeps its own delay words for every
    // coefficient set, computes the filtered value of each accepted sample and
    // compares the block's results against them in order.
    class bandpass_scoreboard;
        longint         coef_q22 [DEFINED_SETS][DEFINED_SECTIONS][TAPS];
        longint         z1_word [FILTER_SETS][SECTIONS];
        longint         z2_word [FILTER_SETS][SECTIONS];
        int             active_set;
        t_filter_result awaited_q [$];
        int             mismatches;
        int             matched;
        int             clipped;

        function new();
            int s;
            int k;
            int t;
            for (s = 0; s < DEFINED_SETS; s++) begin
                for (k = 0; k < DEFINED_SECTIONS; k++) begin
                    for (t = 0; t < TAPS; t++) begin
                        coef_q22[s][k][t] = to_q22(COEF_E8[s][k][t]);
                    end
                end
            end
            for (s = 0; s < FILTER_SETS; s++) begin
                for (k = 0; k < SECTIONS; k++) begin
                    z1_word[s][k] = 0;
                    z2_word[s][k] = 0;
                end
            end
            active_set = 0;
            mismatches = 0;
            matched = 0;
            clipped = 0;
        endfunction

        // Rounds half away from zero, as the coefficients were specified.
        function longint to_q22(longint e8);
            longint mag;
            longint q;
            mag = (e8 < 0) ? -e8 : e8;
            q = (mag * 4194304 + 50000000) / 100000000;
            return (e8 < 0) ? -q : q;
        endfunction

        // Q2.22 times Q.16, back to Q.16 with a half LSB added and the floor taken.
        function longint round_product(longint c, longint v);
            return (c * v + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        endfunction

        function longint clip(longint v, int bits, inout bit hit);
            longint top;
            top = (longint'(1) << (bits - 1)) - 1;
            if (v > top) begin
                hit = 1'b1;
                return top;
            end
            if (v < -top - 1) begin
                hit = 1'b1;
                return -top - 1;
            end
            return v;
        endfunction

        function void select_set(logic [MODE_W-1:0] m);
            active_set = (int'(m) >= FILTER_SETS) ? 0 : int'(m);
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] s);
            longint         v;
            longint         w;
            longint         y;
            longint         z1;
            longint         z2;
            bit             hit;
            int             k;
            t_filter_result r;
            hit = 1'b0;
            v = longint'(s) << FRAC_IN;
            for (k = 0; k < SECTIONS; k++) begin
                if (active_set >= DEFINED_SETS || k >= DEFINED_SECTIONS) begin
                    continue;
                end
                z1 = z1_word[active_set][k];
                z2 = z2_word[active_set][k];
                w = v - round_product(coef_q22[active_set][k][3], z1)
                      - round_product(coef_q22[active_set][k][4], z2);
                w = clip(w, DELAY_W, hit);
                y = round_product(coef_q22[active_set][k][0], w)
                  + round_product(coef_q22[active_set][k][1], z1)
                  + round_product(coef_q22[active_set][k][2], z2);
                v = clip(y, DELAY_W, hit);
                z2_word[active_set][k] = z1;
                z1_word[active_set][k] = w;
            end
            v = clip(v, OUT_W, hit);
            r.filtered = t_out'(v);
            r.saturated = hit;
            awaited_q.push_back(r);
        endfunction

        function void check_result(t_out got_filtered, logic got_saturated);
            t_filter_result want;
            if (awaited_q.size() == 0) begin
                $error("unexpected result: filtered %0d, saturated %0b",
                       got_filtered, got_saturated);
                mismatches++;
                return;
            end
            want = awaited_q.pop_front();
            if (got_filtered !== want.filtered) begin
                $error("filtered: expected %0d, actual %0d", want.filtered, got_filtered);
                mismatches++;
            end
            if (got_saturated !== want.saturated) begin
                $error("saturated: expected %0b, actual %0b",
                       want.saturated, got_saturated);
                mismatches++;
            end
            matched++;
            if (want.saturated) begin
                clipped++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bbcf_sample_if smp_if ();
    bbcf_result_if res_if ();

    bandpass_scoreboard sb;

    // Idling switches for the two sides; both are turned off for a long stretch.
    bit sender_idles;
    bit sink_stalls;
    int items_sent;
    int mode_writes;
    int readback_errors;
    int wander_level;

    biosignal_biquad_cascade_filter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The run is cut short here if the block stops making progress.
    initial begin : watchdog
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: takes each offered result when ready is high and checks it.
    // Ready is withheld in about a third of the cycles while stalling is on.
    initial begin : result_sink
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                sb.check_result(res_if.filtered, res_if.saturated);
            end
            res_if.ready <= (sink_stalls && $urandom_range(99) < 33) ? 1'b0 : 1'b1;
        end
    end

    // Offers one sample and returns at the edge where it is accepted. Valid is
    // left high so that a following item can go straight out; a random gap may
    // come first, which lands on every step of the block's sequence.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        if (sender_idles && $urandom_range(99) < 33) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.sample <= s;
        do begin
            @(posedge i_clk);
        end while (!smp_if.ready);
        sb.note_sample(s);
        items_sent++;
    endtask

    // Withdraws valid and waits until every awaited result has been checked.
    task automatic drain();
        smp_if.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes the mode register and reads it straight back. The read setup
    // follows the write access directly, so psel stays high throughout. The
    // upper data bits are random, since only the mode field is kept.
    task automatic set_filter_mode(input logic [MODE_W-1:0] m);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MODE_ADDR;
        pwdata <= {30'($urandom_range(0, (1 << 30) - 1)), m};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        sb.select_set(m);
        mode_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (prdata[MODE_W-1:0] !== m) begin
            $error("filter_mode read-back: expected %0d, actual %0d", m, prdata[MODE_W-1:0]);
            readback_errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sends a number of samples as a string of randomly shaped segments.
    task automatic play_samples(input int count);
        t_shape                  shape;
        int                      seg_len;
        int                      i;
        int                      pick;
        logic [SAMPLE_BITS-1:0]  held;
        logic [SAMPLE_BITS-1:0]  s;
        while (count > 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                shape = SHAPE_NOISE;
            end else if (pick < 6) begin
                shape = SHAPE_WANDER;
            end else if (pick < 8) begin
                shape = SHAPE_HOLD;
            end else begin
                shape = SHAPE_TOGGLE;
            end
            seg_len = (shape == SHAPE_HOLD) ? $urandom_range(10, 60) : $urandom_range(4, 30);
            if (seg_len > count) begin
                seg_len = count;
            end
            held = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
            for (i = 0; i < seg_len; i++) begin
                case (shape)
                    SHAPE_NOISE: begin
                        s = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
                    end
                    SHAPE_WANDER: begin
                        wander_level = wander_level + int'($urandom_range(0, 60)) - 30;
                        if (wander_level < 0) begin
                            wander_level = 0;
                        end else if (wander_level > SAMPLE_MAX) begin
                            wander_level = SAMPLE_MAX;
                        end
                        s = SAMPLE_BITS'(wander_level);
                    end
                    SHAPE_HOLD: begin
                        s = held;
                    end
                    default: begin
                        s = (i % 2 == 0) ? held : ~held;
                    end
                endcase
                send_sample(s);
            end
            count -= seg_len;
        end
    endtask

    initial begin : stimulus
        int b;
        int p;
        sb = new();
        items_sent = 0;
        mode_writes = 0;
        readback_errors = 0;
        wander_level = SAMPLE_MAX / 2;
        sender_idles = 1'b1;
        sink_stalls = 1'b1;
        i_rst_n <= 1'b0;
        smp_if.valid <= 1'b0;
        smp_if.sample <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run in the reset mode (ECG) without writing it: the
        // extremes of the sample, full-scale steps both ways, each bit alone
        // and the two codes either side of mid-scale.
        send_sample('0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample('0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        for (b = 0; b < SAMPLE_BITS; b++) begin
            send_sample(SAMPLE_BITS'(1 << b));
        end
        send_sample(SAMPLE_BITS'(SAMPLE_MAX / 2));
        send_sample(SAMPLE_BITS'(SAMPLE_MAX / 2 + 1));
        send_sample(SAMPLE_BITS'(SAMPLE_MAX - 1));
        send_sample(SAMPLE_BITS'(1));
        drain();

        // Random phases. The mode only changes once all results are back, so
        // each write falls while the block is idle. Phases 2 and 3 run with no
        // idling on either side; phase 4 also pauses half-way until every
        // result has come back.
        for (p = 0; p < PHASES; p++) begin
            set_filter_mode(PHASE_MODES[p]);
            sender_idles = !(p == 2 || p == 3);
            sink_stalls = !(p == 2 || p == 3);
            play_samples(PHASE_ITEMS / 2);
            if (p == 4) begin
                drain();
            end
            play_samples(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain();
        end

        // Any stray result in this window shows up as an unexpected one.
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d samples over %0d mode writes; %0d results checked.",
                 items_sent, mode_writes, sb.matched);
        $display("Of those, %0d were expected to report clipping.", sb.clipped);
        if (sb.mismatches == 0 && readback_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
